// File: design/lwb_pkg.sv
// Link weight balancer: shared constants, request codes and the
// controller/datapath command and status types. No dependencies.
package lwb_pkg;

  localparam int NUM_LINKS  = 8;
  localparam int IDX_W      = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int ENTRY_W    = 65;  // {alive, tick[31:0], weight[31:0]}
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic signed [31:0] MIN_SEARCH_CEILING = 32'sd2147483647;

  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DIVISOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_DIVISOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_MIN_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT  = 3'd5;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_LAND = 2'd1,
    REQ_SET  = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_RD_IDX,
    DP_RD_CNT,
    DP_SET_WR,
    DP_ADD_EVAL,
    DP_DIV_ADD,
    DP_ADD_Q,
    DP_ADD_WR,
    DP_LAND_OWN,
    DP_MIN_CMP,
    DP_MIN_FIX,
    DP_DIV_LAND,
    DP_MINQ,
    DP_LAND_WR,
    DP_CAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       oor;
    logic       need_div;
    logic       mode;
    logic       div_busy;
  } status_t;

endpackage

// File: design/lwb_if.sv
// Link weight balancer: request and result channel interfaces.
// Valid/ready handshake; no dependencies.
interface lwb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [2:0]         conn_index;
  logic signed [31:0] avg_delay;
  logic [31:0]        now_seconds;
  logic               load_alive;
  logic [31:0]        load_tick;
  logic signed [31:0] load_weight;

  modport source (output valid, req_type, conn_index, avg_delay, now_seconds,
                  load_alive, load_tick, load_weight, input ready);
  modport sink   (input valid, req_type, conn_index, avg_delay, now_seconds,
                  load_alive, load_tick, load_weight, output ready);
endinterface

interface lwb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] link_weight;

  modport source (output valid, link_weight, input ready);
  modport sink   (input valid, link_weight, output ready);
endinterface

// File: design/lwb_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module lwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lwb_div.sv
// Iterative unsigned divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle. No dependencies.
module lwb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r, q_nxt;
  logic [15:0] d_r;
  logic [16:0] r_r, r_nxt;
  logic [16:0] trial;

  always_comb begin
    trial = {r_r[15:0], q_r[31]};
    if (trial >= {1'b0, d_r}) begin
      r_nxt = trial - {1'b0, d_r};
      q_nxt = {q_r[30:0], 1'b1};
    end else begin
      r_nxt = trial;
      q_nxt = {q_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// File: design/lwb_ctrl.sv
// Link weight balancer controller: request sequencing and handshake.
// Depends on lwb_pkg.
module lwb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lwb_pkg::status_t status,
  output lwb_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ADD_EVAL, S_ADD_DIV, S_ADD_WAIT, S_ADD_Q, S_ADD_WR,
    S_LAND_OWN, S_SCAN_RD, S_SCAN_CMP, S_MIN_FIX, S_LAND_DIV, S_LAND_WAIT,
    S_MINQ, S_UPD_RD, S_UPD_WR, S_SET_WR, S_FIN_RD, S_CAP
  } state_t;

  localparam logic [lwb_pkg::IDX_W-1:0] CNT_LAST =
    lwb_pkg::IDX_W'(lwb_pkg::NUM_LINKS - 1);

  state_t                      state_r, state_nxt;
  logic [lwb_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        room;

  assign room = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = lwb_pkg::DP_NOP;
    cmd.cnt       = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = lwb_pkg::DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.op = lwb_pkg::DP_RD_IDX;
        if (status.oor) begin
          state_nxt = S_CAP;
        end else begin
          case (status.req)
            lwb_pkg::REQ_ADD:  state_nxt = S_ADD_EVAL;
            lwb_pkg::REQ_LAND: state_nxt = S_LAND_OWN;
            lwb_pkg::REQ_SET:  state_nxt = S_SET_WR;
            default:           state_nxt = S_FIN_RD;
          endcase
        end
      end
      S_ADD_EVAL: begin
        cmd.op    = lwb_pkg::DP_ADD_EVAL;
        state_nxt = status.need_div ? S_ADD_DIV : S_ADD_WR;
      end
      S_ADD_DIV: begin
        cmd.op    = lwb_pkg::DP_DIV_ADD;
        state_nxt = S_ADD_WAIT;
      end
      S_ADD_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_ADD_Q;
        end
      end
      S_ADD_Q: begin
        cmd.op    = lwb_pkg::DP_ADD_Q;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.op    = lwb_pkg::DP_ADD_WR;
        state_nxt = S_FIN_RD;
      end
      S_LAND_OWN: begin
        cmd.op    = lwb_pkg::DP_LAND_OWN;
        cnt_nxt   = '0;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.op    = lwb_pkg::DP_RD_CNT;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.op = lwb_pkg::DP_MIN_CMP;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_MIN_FIX;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_MIN_FIX: begin
        cmd.op    = lwb_pkg::DP_MIN_FIX;
        state_nxt = status.mode ? S_LAND_DIV : S_UPD_RD;
      end
      S_LAND_DIV: begin
        cmd.op    = lwb_pkg::DP_DIV_LAND;
        state_nxt = S_LAND_WAIT;
      end
      S_LAND_WAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_MINQ;
        end
      end
      S_MINQ: begin
        cmd.op    = lwb_pkg::DP_MINQ;
        state_nxt = S_UPD_RD;
      end
      S_UPD_RD: begin
        cmd.op    = lwb_pkg::DP_RD_CNT;
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.op = lwb_pkg::DP_LAND_WR;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_UPD_RD;
        end
      end
      S_SET_WR: begin
        cmd.op    = lwb_pkg::DP_SET_WR;
        state_nxt = S_FIN_RD;
      end
      S_FIN_RD: begin
        cmd.op    = lwb_pkg::DP_RD_IDX;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        if (room) begin
          cmd.op        = lwb_pkg::DP_CAP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/lwb_dp.sv
// Link weight balancer datapath: config registers, link entry RAM,
// minimum search, weight update arithmetic and divider.
// Depends on lwb_pkg, lwb_ram, lwb_div.
module lwb_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      req_type,
  input  logic [2:0]                      conn_index,
  input  logic signed [31:0]              avg_delay,
  input  logic [31:0]                     now_seconds,
  input  logic                            load_alive,
  input  logic [31:0]                     load_tick,
  input  logic signed [31:0]              load_weight,
  input  logic                            cfg_we,
  input  logic [lwb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lwb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  lwb_pkg::cmd_t                   cmd,
  output lwb_pkg::status_t                status,
  output logic signed [31:0]              link_weight
);

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return v[31:0];
  endfunction

  // config
  logic        mode_r;
  logic [15:0] drop_r, ddiv_r, udiv_r, step_r;
  logic [30:0] noise_r;

  // request
  logic [1:0]         req_r;
  logic [2:0]         conn_r;
  logic               oor_r;
  logic signed [31:0] delay_r;
  logic [31:0]        now_r;
  logic               la_r;
  logic [31:0]        lt_r;
  logic signed [31:0] lw_r;

  // working
  logic signed [31:0] own_w_r, min_r, minq_r, res_r;
  logic [30:0]        inc_r;

  logic [lwb_pkg::NUM_LINKS-1:0] vld_r;
  logic                          rd_vld_r;

  logic [lwb_pkg::IDX_W-1:0]   idx_a, raddr, waddr;
  logic                        re, we;
  logic [lwb_pkg::ENTRY_W-1:0] wdata, rd_q;

  logic               ent_alive;
  logic [31:0]        ent_tick;
  logic signed [31:0] ent_w;
  logic signed [33:0] age, age_lim;
  logic               fresh;

  logic [15:0]        udiv_eff, ddiv_eff;
  logic signed [32:0] delay_x;
  logic               need_div;

  logic               div_start, div_busy;
  logic [31:0]        div_dividend, div_q;
  logic [15:0]        div_divisor;
  logic [31:0]        min_abs;

  logic signed [31:0] add_w, land_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      drop_r  <= 16'd5;
      ddiv_r  <= 16'd1;
      udiv_r  <= 16'd1;
      step_r  <= 16'd1;
      noise_r <= 31'd100000;
    end else if (cfg_we) begin
      case (cfg_index)
        lwb_pkg::CFG_LANDING_MODE: mode_r  <= cfg_data[0];
        lwb_pkg::CFG_DROP_PERIOD:  drop_r  <= cfg_data[15:0];
        lwb_pkg::CFG_DOWN_DIVISOR: ddiv_r  <= cfg_data[15:0];
        lwb_pkg::CFG_UP_DIVISOR:   udiv_r  <= cfg_data[15:0];
        lwb_pkg::CFG_UP_MIN_STEP:  step_r  <= cfg_data[15:0];
        lwb_pkg::CFG_NOISE_LIMIT:  noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx_a = lwb_pkg::IDX_W'(conn_r);

  // entry read side; never-written entries read as zero
  assign ent_alive = rd_vld_r & rd_q[64];
  assign ent_tick  = rd_vld_r ? rd_q[63:32] : 32'd0;
  assign ent_w     = rd_vld_r ? $signed(rd_q[31:0]) : 32'sd0;

  assign age     = $signed({2'b00, now_r}) - $signed({2'b00, ent_tick});
  assign age_lim = $signed({18'd0, drop_r}) + 34'sd2;
  assign fresh   = ent_alive && (age < age_lim);

  assign udiv_eff = (udiv_r == 16'd0) ? 16'd1 : udiv_r;
  assign ddiv_eff = (ddiv_r == 16'd0) ? 16'd1 : ddiv_r;
  assign delay_x  = {delay_r[31], delay_r};
  assign need_div = (delay_x > $signed({17'd0, udiv_eff})) &&
                    (delay_x > $signed({17'd0, step_r}));

  assign min_abs = min_r[31] ? (32'd0 - min_r) : min_r;

  assign div_start    = (cmd.op == lwb_pkg::DP_DIV_ADD) ||
                        (cmd.op == lwb_pkg::DP_DIV_LAND);
  assign div_dividend = (cmd.op == lwb_pkg::DP_DIV_LAND) ? min_abs : delay_r;
  assign div_divisor  = (cmd.op == lwb_pkg::DP_DIV_LAND) ? ddiv_eff : udiv_eff;

  lwb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign add_w = sat32({own_w_r[31], own_w_r} + $signed({2'b00, inc_r}));

  always_comb begin
    if (mode_r) begin
      land_w = (ent_w == min_r) ? 32'sd0 :
               sat32({ent_w[31], ent_w} - {minq_r[31], minq_r});
    end else begin
      land_w = sat32({ent_w[31], ent_w} - {min_r[31], min_r});
    end
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx_a;
    waddr = idx_a;
    wdata = {la_r, lt_r, lw_r};
    case (cmd.op)
      lwb_pkg::DP_RD_IDX: re = 1'b1;
      lwb_pkg::DP_RD_CNT: begin
        re    = 1'b1;
        raddr = cmd.cnt;
      end
      lwb_pkg::DP_SET_WR: we = 1'b1;
      lwb_pkg::DP_ADD_WR: begin
        we    = 1'b1;
        wdata = {ent_alive, ent_tick, add_w};
      end
      lwb_pkg::DP_LAND_WR: begin
        we    = fresh;
        waddr = cmd.cnt;
        wdata = {ent_alive, ent_tick, land_w};
      end
      default: ;
    endcase
  end

  lwb_ram #(
    .WIDTH (lwb_pkg::ENTRY_W),
    .DEPTH (lwb_pkg::NUM_LINKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lwb_pkg::DP_LATCH: begin
        req_r   <= req_type;
        conn_r  <= conn_index;
        oor_r   <= (32'(conn_index) >= lwb_pkg::NUM_LINKS);
        delay_r <= avg_delay;
        now_r   <= now_seconds;
        la_r    <= load_alive;
        lt_r    <= load_tick;
        lw_r    <= load_weight;
      end
      lwb_pkg::DP_ADD_EVAL: begin
        own_w_r <= ent_w;
        inc_r   <= {15'd0, step_r};
      end
      lwb_pkg::DP_ADD_Q: begin
        inc_r <= (div_q < {1'b0, noise_r}) ? div_q[30:0] : delay_r[30:0];
      end
      lwb_pkg::DP_LAND_OWN: begin
        own_w_r <= ent_w;
        min_r   <= lwb_pkg::MIN_SEARCH_CEILING;
      end
      lwb_pkg::DP_MIN_CMP: begin
        if (fresh && (ent_w < min_r)) begin
          min_r <= ent_w;
        end
      end
      lwb_pkg::DP_MIN_FIX: begin
        if (min_r == lwb_pkg::MIN_SEARCH_CEILING) begin
          min_r <= own_w_r;
        end
      end
      lwb_pkg::DP_MINQ: begin
        minq_r <= min_r[31] ? (32'sd0 - $signed(div_q)) : $signed(div_q);
      end
      lwb_pkg::DP_CAP: begin
        res_r <= oor_r ? 32'sd0 : ent_w;
      end
      default: ;
    endcase
  end

  assign status.req      = req_r;
  assign status.oor      = oor_r;
  assign status.need_div = need_div;
  assign status.mode     = mode_r;
  assign status.div_busy = div_busy;

  assign link_weight = res_r;

endmodule

// File: design/link_weight_balancer_top.sv
// Link weight balancer top level: channel handshakes, controller and
// datapath. Depends on lwb_pkg, lwb_if, lwb_ctrl, lwb_dp.
//
// Usage: one request enters on in_ch when ready is high; ready is high only
// while no request is in progress. Each request gives one result on out_ch:
// the named link's weight after the request. Config writes on cfg_we /
// cfg_index / cfg_data take effect at once; the user must let them go in only
// while idle, as the block itself does not enforce it.
// Request paths: set entry; unused type; link index beyond the table; add
// delay, with or without the quotient path; landing, in plain or divided mode.
// The landing scan and update read one RAM entry at a time, then compare it or
// write its update; the divider produces one quotient bit a cycle. At most one
// request is in flight; a result waiting in the output register does not hold
// off the next accept, but a finished request waits until the register is free.
// Reset (rst_n low, synchronous) restores register defaults and marks all
// link entries empty, so they read as all zero; no clearing pass is run.
module link_weight_balancer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  lwb_in_if.sink                         in_ch,
  lwb_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lwb_pkg::CFG_DATA_W-1:0] cfg_data
);

  lwb_pkg::cmd_t    cmd;
  lwb_pkg::status_t status;
  logic             in_ready, out_valid;

  lwb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lwb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_type    (in_ch.req_type),
    .conn_index  (in_ch.conn_index),
    .avg_delay   (in_ch.avg_delay),
    .now_seconds (in_ch.now_seconds),
    .load_alive  (in_ch.load_alive),
    .load_tick   (in_ch.load_tick),
    .load_weight (in_ch.load_weight),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .link_weight (out_ch.link_weight)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready stayed high after a request was accepted");

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == lwb_pkg::DP_DIV_ADD || cmd.op == lwb_pkg::DP_DIV_LAND)
      |=> status.div_busy)
    else $error("divider did not start");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_busy |-> !in_ch.ready)
    else $error("divider running while idle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a request in progress");

endmodule
